/* rtl/core/cpf_pkg.sv */
// shared constants and types of the command packet framer
package cpf_pkg;

    localparam logic [7:0]  MAX_PAYLOAD = 8'd128;
    localparam logic [7:0]  SYNC_HI     = 8'hEF;
    localparam logic [7:0]  SYNC_LO     = 8'h01;
    localparam logic [31:0] ADDR_RESET  = 32'hFFFF_FFFF;
    localparam logic [7:0]  LEN_EXTRA   = 8'd2;

    typedef enum logic [3:0] {
        POS_SYNC_HI = 4'd0,
        POS_SYNC_LO = 4'd1,
        POS_ADDR_3  = 4'd2,
        POS_ADDR_2  = 4'd3,
        POS_ADDR_1  = 4'd4,
        POS_ADDR_0  = 4'd5,
        POS_TYPE    = 4'd6,
        POS_LEN_HI  = 4'd7,
        POS_LEN_LO  = 4'd8,
        POS_DATA    = 4'd9,
        POS_SUM_HI  = 4'd10,
        POS_SUM_LO  = 4'd11
    } pos_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  ptype;
        logic [15:0] len_total;
        logic [15:0] csum;
        logic        first;
        logic        last;
    } item_t;

endpackage

/* rtl/core/cpf_if.sv */
// word channels of the command packet framer
interface cpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] packet_type;
    logic [7:0] payload_len;

    modport source (output valid, output payload_byte, output packet_type,
                    output payload_len, input ready);
    modport sink (input valid, input payload_byte, input packet_type,
                  input payload_len, output ready);
endinterface

interface cpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

interface cpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] module_address;

    modport source (output valid, output module_address, input ready);
    modport sink (input valid, input module_address, output ready);
endinterface

/* rtl/core/command_packet_framer.sv */
// top level of the command packet framer
// Each accepted payload word is registered with its header, length and
// checksum fields, then sent out one byte per output word: ten words on a
// packet's first payload byte, one on a middle byte, three on the last byte
// and twelve for a one-byte packet, so a packet of N payload bytes takes
// N + 11 output words. The next input word is taken in the same cycle that
// the last output word of the current one is taken, so throughput is set by
// the single byte-wide output port. The module address register resets to
// all ones and the config port is always ready.
module command_packet_framer (
    input  logic clk,
    input  logic rst_n,
    cpf_in_if.sink    din,
    cpf_out_if.source dout,
    cpf_cfg_if.sink   cfg
);
    import cpf_pkg::*;

    logic [31:0] module_address_reg;
    item_t       item_reg;
    item_t       item_new;
    pos_t        pos_reg, pos_next;
    logic        active_reg, active_next;
    logic        accept;
    logic        at_end;
    pos_t        end_pos;

    cpf_frame_ctl u_frame_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (din.payload_byte),
        .packet_type  (din.packet_type),
        .payload_len  (din.payload_len),
        .item         (item_new)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_address_reg <= ADDR_RESET;
        end
        else if (cfg.valid)
        begin
            module_address_reg <= cfg.module_address;
        end
    end

    always_comb
    begin
        end_pos  = item_reg.last ? POS_SUM_LO : POS_DATA;
        at_end   = (pos_reg == end_pos);
        din.ready = !active_reg || (dout.ready && at_end);
        accept   = din.valid && din.ready;

        pos_next    = pos_reg;
        active_next = active_reg;
        if (accept)
        begin
            active_next = 1'b1;
            pos_next    = item_new.first ? POS_SYNC_HI : POS_DATA;
        end
        else if (active_reg && dout.ready)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                pos_next = pos_t'(pos_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_SYNC_HI;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_new;
        end
    end

    always_comb
    begin
        dout.valid     = active_reg;
        dout.frame_end = (pos_reg == POS_SUM_LO);
        case (pos_reg)
            POS_SYNC_HI: dout.out_byte = SYNC_HI;
            POS_SYNC_LO: dout.out_byte = SYNC_LO;
            POS_ADDR_3:  dout.out_byte = module_address_reg[31:24];
            POS_ADDR_2:  dout.out_byte = module_address_reg[23:16];
            POS_ADDR_1:  dout.out_byte = module_address_reg[15:8];
            POS_ADDR_0:  dout.out_byte = module_address_reg[7:0];
            POS_TYPE:    dout.out_byte = item_reg.ptype;
            POS_LEN_HI:  dout.out_byte = item_reg.len_total[15:8];
            POS_LEN_LO:  dout.out_byte = item_reg.len_total[7:0];
            POS_DATA:    dout.out_byte = item_reg.data;
            POS_SUM_HI:  dout.out_byte = item_reg.csum[15:8];
            POS_SUM_LO:  dout.out_byte = item_reg.csum[7:0];
            default:     dout.out_byte = 8'd0;
        endcase
    end

endmodule

/* rtl/core/cpf_frame_ctl.sv */
// packet position tracking and checksum accumulation
module cpf_frame_ctl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    payload_byte,
    input  logic [7:0]    packet_type,
    input  logic [7:0]    payload_len,
    output cpf_pkg::item_t item
);
    import cpf_pkg::*;

    logic [7:0]  bytes_taken_reg, bytes_taken_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  held_length_reg, held_length_next;

    logic        first;
    logic [7:0]  len_sat;
    logic [7:0]  len_eff;
    logic [15:0] len_total;
    logic [15:0] sum_base;
    logic [15:0] sum_new;
    logic [7:0]  taken_new;
    logic        last;

    always_comb
    begin
        first = (bytes_taken_reg == 8'd0);
        if (payload_len == 8'd0)
        begin
            len_sat = 8'd1;
        end
        else if (payload_len > MAX_PAYLOAD)
        begin
            len_sat = MAX_PAYLOAD;
        end
        else
        begin
            len_sat = payload_len;
        end
        len_eff   = first ? len_sat : held_length_reg;
        len_total = {8'd0, len_eff} + {8'd0, LEN_EXTRA};
        sum_base  = first ? ({8'd0, packet_type} + {8'd0, len_total[15:8]}
                             + {8'd0, len_total[7:0]})
                          : running_sum_reg;
        sum_new   = sum_base + {8'd0, payload_byte};
        taken_new = (first ? 8'd0 : bytes_taken_reg) + 8'd1;
        last      = (taken_new >= len_eff);

        item.data      = payload_byte;
        item.ptype     = packet_type;
        item.len_total = len_total;
        item.csum      = sum_new;
        item.first     = first;
        item.last      = last;

        bytes_taken_next = bytes_taken_reg;
        running_sum_next = running_sum_reg;
        held_length_next = held_length_reg;
        if (accept)
        begin
            held_length_next = len_eff;
            bytes_taken_next = last ? 8'd0 : taken_new;
            running_sum_next = last ? 16'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg <= 8'd0;
            running_sum_reg <= 16'd0;
            held_length_reg <= 8'd0;
        end
        else
        begin
            bytes_taken_reg <= bytes_taken_next;
            running_sum_reg <= running_sum_next;
            held_length_reg <= held_length_next;
        end
    end

endmodule
